FILE: design/bfh_pkg.sv
`default_nettype none
package bfh_pkg;

    // request opcodes
    typedef enum logic [2:0] {
        OP_PREV   = 3'd0,
        OP_NEXT   = 3'd1,
        OP_RECORD = 3'd2,
        OP_SHIFT  = 3'd3,
        OP_MOVE   = 3'd4,
        OP_FORGET = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NOP    = 3'd7
    } opcode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_PICK,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // fixed field widths
    localparam int unsigned OPCODE_BITS = 3;
    localparam int unsigned STEP_BITS   = 17;
    localparam int unsigned LEN_BITS    = 16;
    localparam int unsigned DRAW_BITS   = 32;
    localparam int unsigned COUNT_BITS  = 5;

    // stack selectors
    localparam logic SEL_PAST   = 1'b0;
    localparam logic SEL_FUTURE = 1'b1;

endpackage
`default_nettype wire

FILE: design/back_forward_history_store_top.sv
`default_nettype none
// Back/forward history store: two bounded stacks (past, future) of track numbers held in
// one shared RAM as circular buffers, so a push onto a full stack just advances the oldest
// slot. Every request gives exactly one result. Shift range, move and forget walk both
// stacks entry by entry through one compare/add unit and the single RAM read port.
// One request is in work at a time; s_axis_tready is low until its result is registered.
module back_forward_history_store_top #(
    parameter int unsigned HISTORY_DEPTH = 20,
    parameter int unsigned TRACK_BITS    = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // opcode, track_a, track_b, step, list_len, random_draw, zero pad
    input  wire logic [((bfh_pkg::OPCODE_BITS + 2*TRACK_BITS + bfh_pkg::STEP_BITS
                         + bfh_pkg::LEN_BITS + bfh_pkg::DRAW_BITS + 7) / 8) * 8 - 1:0]
                      s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // track, from_history, past_count, future_count, zero pad
    output logic [((TRACK_BITS + 1 + 2*bfh_pkg::COUNT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int unsigned T      = TRACK_BITS;
    localparam int unsigned D      = HISTORY_DEPTH;
    localparam int unsigned IW     = (D > 1) ? $clog2(D) : 1;
    localparam int unsigned CW     = $clog2(D + 1);
    localparam int unsigned AW     = $clog2(2 * D);
    localparam int unsigned SUMW   = ((T > bfh_pkg::STEP_BITS) ? T : bfh_pkg::STEP_BITS) + 2;
    localparam int unsigned OUT_RAW = T + 1 + 2 * bfh_pkg::COUNT_BITS;
    localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int unsigned A_LO   = bfh_pkg::OPCODE_BITS;
    localparam int unsigned B_LO   = A_LO + T;
    localparam int unsigned S_LO   = B_LO + T;
    localparam int unsigned L_LO   = S_LO + bfh_pkg::STEP_BITS;
    localparam int unsigned R_LO   = L_LO + bfh_pkg::LEN_BITS;

    // wrap a sum of two slot indexes into the stack depth
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] x, input logic [IW-1:0] y);
        logic [IW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= (IW+1)'(D))
        begin
            s = s - (IW+1)'(D);
        end
        return s[IW-1:0];
    endfunction

    // RAM address of a physical slot in one stack
    function automatic logic [AW-1:0] ram_addr(input logic sel, input logic [IW-1:0] slot);
        return AW'(slot) + (sel ? AW'(D) : AW'(0));
    endfunction

    bfh_pkg::state_t  state_reg, state_next;
    bfh_pkg::opcode_t op_reg, op_next;
    logic [T-1:0]     a_reg, a_next, b_reg, b_next;
    logic [bfh_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic [bfh_pkg::LEN_BITS-1:0]  len_reg, len_next;
    logic [bfh_pkg::DRAW_BITS-1:0] draw_reg, draw_next;
    logic             sel_reg, sel_next;
    logic [IW-1:0]    base_reg [2];
    logic [IW-1:0]    base_next [2];
    logic [CW-1:0]    fill_reg [2];
    logic [CW-1:0]    fill_next [2];
    logic [CW-1:0]    rd_reg, rd_next, wr_reg, wr_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic             pend_reg, pend_next;
    logic [T-1:0]     track_reg, track_next;
    logic             hist_reg, hist_next;
    logic             ovalid_reg, ovalid_next;
    logic [OUT_W-1:0] odata_reg, odata_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [T-1:0]     ram_wdata, ram_rdata;

    logic             accept;
    logic [T-1:0]     entry;
    logic [SUMW-1:0]  shift_sum;
    logic             in_range;
    logic [T-1:0]     shifted;
    logic [47:0]      product;
    logic [IW-1:0]    cur_base, cur_fill_i;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == bfh_pkg::ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    bfh_ram #(.WIDTH(T), .DEPTH(2 * D)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // shared compare/add unit on the entry read back
    assign entry     = ram_rdata;
    assign in_range  = (entry >= a_reg) && (entry <= b_reg);
    assign shift_sum = SUMW'(entry)
                     + {{(SUMW - bfh_pkg::STEP_BITS){step_reg[bfh_pkg::STEP_BITS-1]}}, step_reg};
    always_comb
    begin
        if (shift_sum[SUMW-1])
        begin
            shifted = '0;
        end
        else if (shift_sum > SUMW'({T{1'b1}}))
        begin
            shifted = '1;
        end
        else
        begin
            shifted = shift_sum[T-1:0];
        end
    end

    // random fallback scaling
    assign product = 48'(draw_reg) * 48'(len_reg);

    assign cur_base   = base_reg[sel_reg];
    assign cur_fill_i = IW'(fill_reg[sel_reg]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (bfh_pkg::opcode_t'(s_axis_tdata[A_LO-1:0]))
                        bfh_pkg::OP_PREV, bfh_pkg::OP_NEXT, bfh_pkg::OP_RECORD:
                            state_next = bfh_pkg::ST_PUSH;
                        bfh_pkg::OP_SHIFT, bfh_pkg::OP_MOVE, bfh_pkg::OP_FORGET:
                            state_next = bfh_pkg::ST_SWEEP;
                        default:
                            state_next = bfh_pkg::ST_DONE;
                    endcase
                end
            end
            bfh_pkg::ST_PUSH:
            begin
                if (op_reg == bfh_pkg::OP_RECORD)
                begin
                    state_next = bfh_pkg::ST_DONE;
                end
                else if (fill_reg[~sel_reg] != '0)
                begin
                    state_next = bfh_pkg::ST_POP_RD;
                end
                else
                begin
                    state_next = bfh_pkg::ST_PICK;
                end
            end
            bfh_pkg::ST_POP_RD:   state_next = bfh_pkg::ST_POP_WAIT;
            bfh_pkg::ST_POP_WAIT: state_next = bfh_pkg::ST_DONE;
            bfh_pkg::ST_PICK:     state_next = bfh_pkg::ST_DONE;
            bfh_pkg::ST_SWEEP:
            begin
                if (rd_reg == fill_reg[sel_reg] && !pend_reg && sel_reg == bfh_pkg::SEL_FUTURE)
                begin
                    state_next = bfh_pkg::ST_DONE;
                end
            end
            bfh_pkg::ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    state_next = bfh_pkg::ST_IDLE;
                end
            end
            default: state_next = bfh_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        step_next    = step_reg;
        len_next     = len_reg;
        draw_next    = draw_reg;
        sel_next     = sel_reg;
        base_next[0] = base_reg[0];
        base_next[1] = base_reg[1];
        fill_next[0] = fill_reg[0];
        fill_next[1] = fill_reg[1];
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        pidx_next    = pidx_reg;
        pend_next    = 1'b0;
        track_next   = track_reg;
        hist_next    = hist_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            bfh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = bfh_pkg::opcode_t'(s_axis_tdata[A_LO-1:0]);
                    a_next     = s_axis_tdata[A_LO +: T];
                    b_next     = s_axis_tdata[B_LO +: T];
                    step_next  = s_axis_tdata[S_LO +: bfh_pkg::STEP_BITS];
                    len_next   = s_axis_tdata[L_LO +: bfh_pkg::LEN_BITS];
                    draw_next  = s_axis_tdata[R_LO +: bfh_pkg::DRAW_BITS];
                    track_next = '0;
                    hist_next  = 1'b0;
                    rd_next    = '0;
                    wr_next    = '0;
                    sel_next   = (bfh_pkg::opcode_t'(s_axis_tdata[A_LO-1:0]) == bfh_pkg::OP_PREV)
                               ? bfh_pkg::SEL_FUTURE : bfh_pkg::SEL_PAST;
                    if (bfh_pkg::opcode_t'(s_axis_tdata[A_LO-1:0]) == bfh_pkg::OP_CLEAR)
                    begin
                        fill_next[0] = '0;
                        fill_next[1] = '0;
                        base_next[0] = '0;
                        base_next[1] = '0;
                    end
                end
            end
            bfh_pkg::ST_PUSH:
            begin
                // write the pushed track; a full stack overwrites the oldest slot and advances the base
                ram_we    = 1'b1;
                ram_wdata = a_reg;
                if (fill_reg[sel_reg] >= CW'(D))
                begin
                    ram_waddr          = ram_addr(sel_reg, cur_base);
                    base_next[sel_reg] = wrap_add(cur_base, IW'(1));
                end
                else
                begin
                    ram_waddr          = ram_addr(sel_reg, wrap_add(cur_base, cur_fill_i));
                    fill_next[sel_reg] = fill_reg[sel_reg] + CW'(1);
                end
                sel_next = ~sel_reg;
            end
            bfh_pkg::ST_POP_RD:
            begin
                ram_raddr = ram_addr(sel_reg, wrap_add(cur_base, cur_fill_i - IW'(1)));
                fill_next[sel_reg] = fill_reg[sel_reg] - CW'(1);
            end
            bfh_pkg::ST_POP_WAIT:
            begin
                track_next = ram_rdata;
                hist_next  = 1'b1;
            end
            bfh_pkg::ST_PICK:
            begin
                track_next = T'(product[47:32]);
            end
            bfh_pkg::ST_SWEEP:
            begin
                // issue the next read
                if (rd_reg != fill_reg[sel_reg])
                begin
                    ram_raddr = ram_addr(sel_reg, wrap_add(cur_base, IW'(rd_reg)));
                    pidx_next = IW'(rd_reg);
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                // handle the entry read last cycle
                if (pend_reg)
                begin
                    case (op_reg)
                        bfh_pkg::OP_SHIFT:
                        begin
                            ram_we    = in_range;
                            ram_waddr = ram_addr(sel_reg, wrap_add(cur_base, pidx_reg));
                            ram_wdata = shifted;
                        end
                        bfh_pkg::OP_MOVE:
                        begin
                            ram_we    = (entry == a_reg);
                            ram_waddr = ram_addr(sel_reg, wrap_add(cur_base, pidx_reg));
                            ram_wdata = b_reg;
                        end
                        default:
                        begin
                            ram_we    = (entry != a_reg);
                            ram_waddr = ram_addr(sel_reg, wrap_add(cur_base, IW'(wr_reg)));
                            ram_wdata = entry;
                            if (entry != a_reg)
                            begin
                                wr_next = wr_reg + CW'(1);
                            end
                        end
                    endcase
                end
                // end of one stack
                if (rd_reg == fill_reg[sel_reg] && !pend_reg)
                begin
                    if (op_reg == bfh_pkg::OP_FORGET)
                    begin
                        fill_next[sel_reg] = wr_reg;
                    end
                    sel_next = bfh_pkg::SEL_FUTURE;
                    rd_next  = '0;
                    wr_next  = '0;
                end
            end
            bfh_pkg::ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = OUT_W'({bfh_pkg::COUNT_BITS'(fill_reg[1]),
                                          bfh_pkg::COUNT_BITS'(fill_reg[0]),
                                          hist_reg, track_reg});
                end
            end
            default:
            begin
                ovalid_next = ovalid_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bfh_pkg::ST_IDLE;
            base_reg[0] <= '0;
            base_reg[1] <= '0;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            pend_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg[0] <= base_next[0];
            base_reg[1] <= base_next[1];
            fill_reg[0] <= fill_next[0];
            fill_reg[1] <= fill_next[1];
            pend_reg    <= pend_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        step_reg  <= step_next;
        len_reg   <= len_next;
        draw_reg  <= draw_next;
        sel_reg   <= sel_next;
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        pidx_reg  <= pidx_next;
        track_reg <= track_next;
        hist_reg  <= hist_next;
        odata_reg <= odata_next;
    end

`ifndef SYNTHESIS
    // fill counts never pass the depth
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg[0] <= CW'(D))
        else $error("past fill over depth");
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg[1] <= CW'(D))
        else $error("future fill over depth");
    // a pending read only exists during a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == bfh_pkg::ST_SWEEP))
        else $error("stray pending read");
    // forget compaction never writes ahead of the read pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfh_pkg::ST_SWEEP) |-> (wr_reg <= rd_reg))
        else $error("compaction overtook reads");
`endif

endmodule
`default_nettype wire

FILE: design/bfh_ram.sv
`default_nettype none
module bfh_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sim/tb_back_forward_history_store_top.sv
`default_nettype none
module tb_back_forward_history_store_top;

    localparam int DEPTH = 20;
    localparam int TB = 16;
    localparam int SW = 3 + 2*TB + 17 + 16 + 32;
    localparam int SWP = ((SW + 7) / 8) * 8;
    localparam int MWP = ((TB + 1 + 10 + 7) / 8) * 8;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // opcode, track_a, track_b, step, list_len, random_draw, zero pad
    logic [SWP-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // track, from_history, past_count, future_count, zero pad
    logic [MWP-1:0] m_axis_tdata;

    back_forward_history_store_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct packed {
        logic [31:0]      draw;
        logic [15:0]      len;
        logic [16:0]      step;
        logic [15:0]      tb;
        logic [15:0]      ta;
        bfh_pkg::opcode_t op;
    } request_t;

    typedef struct packed {
        logic [4:0]  fcount;
        logic [4:0]  pcount;
        logic        hist;
        logic [15:0] track;
    } answer_t;

    // directed row: request plus optional typed-in answer
    typedef struct {
        request_t req;
        bit       known;
        answer_t  ans;
    } row_t;

    // history predictor state
    logic [15:0] past_q[$];
    logic [15:0] future_q[$];
    answer_t expected_answers[$];

    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  failed;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("[back_forward_history_store_top] ERROR");
        $finish;
    end

    function automatic void push_track(ref logic [15:0] q[$], input logic [15:0] v);
        if (q.size() >= DEPTH)
            void'(q.pop_front());
        q.push_back(v);
    endfunction

    function automatic logic [15:0] random_pick(logic [31:0] draw, logic [15:0] len);
        logic [47:0] prod;
        prod = {16'd0, draw} * {32'd0, len};
        return prod[47:32];
    endfunction

    function automatic void shift_range(ref logic [15:0] q[$], input logic [15:0] lo,
                                        input logic [15:0] hi, input logic signed [16:0] st);
        int v;
        foreach (q[i])
        begin
            if (q[i] >= lo && q[i] <= hi)
            begin
                v = int'(q[i]) + int'(st);
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                q[i] = v[15:0];
            end
        end
    endfunction

    function automatic void forget_track(ref logic [15:0] q[$], input logic [15:0] t);
        logic [15:0] kept[$];
        foreach (q[i])
            if (q[i] != t)
                kept.push_back(q[i]);
        q = kept;
    endfunction

    // compute the answer for one request and advance the predicted stacks
    function automatic answer_t predict_history(request_t r);
        answer_t a;
        a = '0;
        case (r.op)
            bfh_pkg::OP_PREV:
            begin
                push_track(future_q, r.ta);
                if (past_q.size() > 0)
                begin
                    a.track = past_q.pop_back();
                    a.hist = 1'b1;
                end
                else
                    a.track = random_pick(r.draw, r.len);
            end
            bfh_pkg::OP_NEXT:
            begin
                push_track(past_q, r.ta);
                if (future_q.size() > 0)
                begin
                    a.track = future_q.pop_back();
                    a.hist = 1'b1;
                end
                else
                    a.track = random_pick(r.draw, r.len);
            end
            bfh_pkg::OP_RECORD:
                push_track(past_q, r.ta);
            bfh_pkg::OP_SHIFT:
            begin
                shift_range(past_q, r.ta, r.tb, r.step);
                shift_range(future_q, r.ta, r.tb, r.step);
            end
            bfh_pkg::OP_MOVE:
            begin
                foreach (past_q[i])
                    if (past_q[i] == r.ta)
                        past_q[i] = r.tb;
                foreach (future_q[i])
                    if (future_q[i] == r.ta)
                        future_q[i] = r.tb;
            end
            bfh_pkg::OP_FORGET:
            begin
                forget_track(past_q, r.ta);
                forget_track(future_q, r.ta);
            end
            bfh_pkg::OP_CLEAR:
            begin
                past_q.delete();
                future_q.delete();
            end
            default: ;
        endcase
        a.pcount = 5'(past_q.size());
        a.fcount = 5'(future_q.size());
        return a;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int n;
        r.draw = $urandom;
        r.len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                            : 16'($urandom);
        r.step = 17'($urandom_range(0, 131070) - 65535);
        if ($urandom_range(0, 1))
            r.step = 17'($urandom_range(0, 40) - 20);
        // favor small track values so edits hit stored entries
        r.ta = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        r.tb = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        if (r.ta > r.tb && $urandom_range(0, 2) != 0)
        begin
            r.ta = r.tb ^ r.ta;
            r.tb = r.tb ^ r.ta;
            r.ta = r.tb ^ r.ta;
        end
        n = $urandom_range(0, 99);
        if (n < 25)
            r.op = bfh_pkg::OP_PREV;
        else if (n < 50)
            r.op = bfh_pkg::OP_NEXT;
        else if (n < 70)
            r.op = bfh_pkg::OP_RECORD;
        else if (n < 78)
            r.op = bfh_pkg::OP_SHIFT;
        else if (n < 86)
            r.op = bfh_pkg::OP_MOVE;
        else if (n < 94)
            r.op = bfh_pkg::OP_FORGET;
        else if (n < 97)
            r.op = bfh_pkg::OP_CLEAR;
        else
            r.op = bfh_pkg::OP_NOP;
        return r;
    endfunction

    function automatic request_t mk(bfh_pkg::opcode_t op, int ta, int tb, int st, int len,
                                    logic [31:0] draw);
        request_t r;
        r.op = op;
        r.ta = ta[15:0];
        r.tb = tb[15:0];
        r.step = st[16:0];
        r.len = len[15:0];
        r.draw = draw;
        return r;
    endfunction

    // idle cycles drop tvalid, then one request is held until accepted
    task automatic send_request(request_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= SWP'(r);
        s_axis_tvalid <= 1'b1;
        expected_answers.push_back(predict_history(r));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_phase(int idle, int stall);
        sender_idle_pct = idle;
        receiver_stall_pct = stall;
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // compare each accepted answer with the oldest prediction
    always @(posedge clk)
    begin
        answer_t got;
        answer_t exp_a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = answer_t'(m_axis_tdata[26:0]);
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected answer %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                exp_a = expected_answers.pop_front();
                if (got.track !== exp_a.track)
                begin
                    $display("%0t: track exp %h got %h", $time, exp_a.track, got.track);
                    failed = 1'b1;
                end
                if (got.hist !== exp_a.hist)
                begin
                    $display("%0t: from_history exp %b got %b", $time, exp_a.hist, got.hist);
                    failed = 1'b1;
                end
                if (got.pcount !== exp_a.pcount)
                begin
                    $display("%0t: past_count exp %0d got %0d", $time, exp_a.pcount,
                             got.pcount);
                    failed = 1'b1;
                end
                if (got.fcount !== exp_a.fcount)
                begin
                    $display("%0t: future_count exp %0d got %0d", $time, exp_a.fcount,
                             got.fcount);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        answer_t pred;
        int guard;
        failed = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        set_phase(0, 0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: empty-stack picks, extremes, every opcode
        rw.known = 1;
        rw.req = mk(bfh_pkg::OP_PREV, 5, 0, 0, 0, 32'hFFFFFFFF);
        rw.ans = '{fcount: 1, pcount: 0, hist: 0, track: 0};
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        rw.ans = '0;
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_NEXT, 65535, 0, 0, 65535, 32'hFFFFFFFF);
        rw.ans = '{fcount: 0, pcount: 1, hist: 0, track: 16'hFFFE};
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_PREV, 7, 0, 0, 65535, 0);
        rw.ans = '{fcount: 1, pcount: 0, hist: 1, track: 16'hFFFF};
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_NOP, 65535, 65535, -1, 65535, 32'hFFFFFFFF);
        rw.ans = '{fcount: 1, pcount: 0, hist: 0, track: 0};
        rows.push_back(rw);
        rw.known = 0;
        for (int i = 0; i < 22; i++)
        begin
            rw.req = mk(bfh_pkg::OP_RECORD, (i == 21) ? 65535 : i, 0, 0, 0, 0);
            rows.push_back(rw);
        end
        rw.req = mk(bfh_pkg::OP_SHIFT, 0, 3, -65535, 0, 0);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_SHIFT, 60000, 65535, 65535, 0, 0);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_SHIFT, 10, 5, 3, 0, 0);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_MOVE, 0, 9, 0, 0, 0);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_FORGET, 9, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_NEXT, 7, 0, 0, 3, 32'h80000000);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_PREV, 8, 0, 0, 3, 32'h80000000);
        rows.push_back(rw);
        rw.req = mk(bfh_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        rows.push_back(rw);

        foreach (rows[i])
        begin
            pred = predict_history(rows[i].req);
            if (rows[i].known && pred !== rows[i].ans)
            begin
                $display("%0t: table row %0d exp %h predictor %h", $time, i,
                         rows[i].ans, pred);
                failed = 1'b1;
            end
        end
        past_q.delete();
        future_q.delete();
        foreach (rows[i])
            send_request(rows[i].req);

        // random part across sender idle and receiver stall phases
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_phase(0, 0);
                1: set_phase(74, 0);
                2: set_phase(0, 74);
                3: set_phase(34, 34);
                default: set_phase(0, 0);
            endcase
            repeat (250) send_request(random_request());
        end
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (expected_answers.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (!failed && expected_answers.size() == 0)
            $display("[back_forward_history_store_top] OK");
        else
            $display("[back_forward_history_store_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
